[rtl/cqr_pkg.sv]
// Shared types, constants and index helpers for the circular queue with reverse.
package cqr_pkg;

	localparam int SLOTS  = 16;
	localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int WORD_W = 32;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		OP_ENQ  = 2'd0,
		OP_DEQ  = 2'd1,
		OP_PEEK = 2'd2,
		OP_REV  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_REV_RD,
		S_REV_WLO,
		S_REV_WHI,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic exec;
		logic rev_rd;
		logic rev_wlo;
		logic rev_whi;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		op_t  op;
		logic rev_work;
		logic rev_last;
	} dp_stat_t;

	function automatic idx_t idx_next(input idx_t i);
		return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
	endfunction

	function automatic idx_t idx_prev(input idx_t i);
		return (i == '0) ? LAST_IDX : i - IDX_W'(1);
	endfunction

endpackage

[rtl/cqr_ctrl.sv]
// Controller: sequences one operation at a time and owns the result valid flag.
module cqr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  cqr_pkg::dp_stat_t dp_stat,
	output cqr_pkg::cmd_t     cmd
);

	cqr_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            out_free;

	assign in_ready  = (state_q == cqr_pkg::S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cqr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Result valid: set on load, cleared by an output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			cqr_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = cqr_pkg::S_EXEC;
				end
			end
			cqr_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				if (dp_stat.op == cqr_pkg::OP_REV && dp_stat.rev_work) begin
					state_d = cqr_pkg::S_REV_RD;
				end else begin
					state_d = cqr_pkg::S_DONE;
				end
			end
			cqr_pkg::S_REV_RD: begin
				cmd.rev_rd = 1'b1;
				state_d    = cqr_pkg::S_REV_WLO;
			end
			cqr_pkg::S_REV_WLO: begin
				cmd.rev_wlo = 1'b1;
				state_d     = cqr_pkg::S_REV_WHI;
			end
			cqr_pkg::S_REV_WHI: begin
				cmd.rev_whi = 1'b1;
				state_d     = dp_stat.rev_last ? cqr_pkg::S_DONE : cqr_pkg::S_REV_RD;
			end
			cqr_pkg::S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = cqr_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = cqr_pkg::S_IDLE;
			end
		endcase
	end

endmodule

[rtl/cqr_dp.sv]
// Datapath: slot store, head/tail indices, reverse walkers and result register.
module cqr_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cqr_pkg::cmd_t            cmd,
	output cqr_pkg::dp_stat_t        dp_stat,
	input  logic [1:0]               op,
	input  logic signed [31:0]       data_in,
	output logic signed [31:0]       data_out,
	output logic [1:0]               status,
	output logic                     is_empty,
	output logic                     is_full
);

	localparam int CNT_W = cqr_pkg::IDX_W + 1;

	cqr_pkg::word_t  mem_q [cqr_pkg::SLOTS];

	cqr_pkg::idx_t    head_q, tail_q;
	cqr_pkg::op_t     op_q;
	cqr_pkg::word_t   word_q;
	cqr_pkg::idx_t    lo_q, hi_q, pairs_q;
	cqr_pkg::word_t   rd_a_q, rd_b_q;
	cqr_pkg::status_t res_status_q;
	logic             res_mem_q, res_neg_q;

	cqr_pkg::word_t   data_out_q;
	cqr_pkg::status_t status_q;
	logic             empty_out_q, full_out_q;

	cqr_pkg::idx_t    tail_nx;
	logic             empty, full;
	logic [CNT_W-1:0] t1, cnt_raw, cnt;
	cqr_pkg::idx_t    pairs_calc;

	logic             we;
	cqr_pkg::idx_t    waddr;
	cqr_pkg::word_t   wdata;
	logic             rd_a_en;
	cqr_pkg::idx_t    rd_a_addr;

	// Occupancy flags and pair count for reverse
	always_comb begin
		tail_nx = cqr_pkg::idx_next(tail_q);
		empty   = (head_q == tail_nx);
		full    = (head_q == cqr_pkg::idx_next(tail_nx));
		t1      = {1'b0, tail_q} + CNT_W'(1);
		if (t1 >= {1'b0, head_q}) begin
			cnt_raw = t1 - {1'b0, head_q};
		end else begin
			cnt_raw = CNT_W'(cqr_pkg::SLOTS) - ({1'b0, head_q} - t1);
		end
		cnt        = (cnt_raw == CNT_W'(cqr_pkg::SLOTS)) ? '0 : cnt_raw;
		pairs_calc = cnt[CNT_W-1:1];
	end

	assign dp_stat.op       = op_q;
	assign dp_stat.rev_work = !empty && (pairs_calc != '0);
	assign dp_stat.rev_last = (pairs_q == cqr_pkg::IDX_W'(1));

	// Write port select
	always_comb begin
		we    = 1'b0;
		waddr = tail_nx;
		wdata = word_q;
		if (cmd.rev_wlo) begin
			we    = 1'b1;
			waddr = lo_q;
			wdata = rd_b_q;
		end else if (cmd.rev_whi) begin
			we    = 1'b1;
			waddr = hi_q;
			wdata = rd_a_q;
		end else if (cmd.exec && op_q == cqr_pkg::OP_ENQ && !full) begin
			we = 1'b1;
		end
	end

	assign rd_a_en   = cmd.rev_rd ||
		(cmd.exec && (op_q == cqr_pkg::OP_DEQ || op_q == cqr_pkg::OP_PEEK) && !empty);
	assign rd_a_addr = cmd.rev_rd ? lo_q : head_q;

	// Slot store: one write, two registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_a_en) begin
			rd_a_q <= mem_q[rd_a_addr];
		end
		if (cmd.rev_rd) begin
			rd_b_q <= mem_q[hi_q];
		end
	end

	// Head and tail indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= cqr_pkg::LAST_IDX;
		end else if (cmd.exec) begin
			if (op_q == cqr_pkg::OP_ENQ && !full) begin
				tail_q <= tail_nx;
			end
			if (op_q == cqr_pkg::OP_DEQ && !empty) begin
				head_q <= cqr_pkg::idx_next(head_q);
			end
		end
	end

	// Item capture, result selection and reverse walkers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= cqr_pkg::op_t'(op);
			word_q <= data_in;
		end
		if (cmd.exec) begin
			unique case (op_q)
				cqr_pkg::OP_ENQ: begin
					res_mem_q    <= 1'b0;
					res_neg_q    <= 1'b0;
					res_status_q <= full ? cqr_pkg::ST_FULL : cqr_pkg::ST_OK;
				end
				cqr_pkg::OP_DEQ, cqr_pkg::OP_PEEK: begin
					res_mem_q    <= !empty;
					res_neg_q    <= empty;
					res_status_q <= empty ? cqr_pkg::ST_EMPTY : cqr_pkg::ST_OK;
				end
				cqr_pkg::OP_REV: begin
					res_mem_q    <= 1'b0;
					res_neg_q    <= 1'b0;
					res_status_q <= empty ? cqr_pkg::ST_EMPTY : cqr_pkg::ST_OK;
					lo_q         <= head_q;
					hi_q         <= tail_q;
					pairs_q      <= pairs_calc;
				end
				default: begin
					res_mem_q    <= 1'b0;
					res_neg_q    <= 1'b0;
					res_status_q <= cqr_pkg::ST_OK;
				end
			endcase
		end
		if (cmd.rev_whi) begin
			lo_q    <= cqr_pkg::idx_next(lo_q);
			hi_q    <= cqr_pkg::idx_prev(hi_q);
			pairs_q <= pairs_q - cqr_pkg::IDX_W'(1);
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			data_out_q  <= res_mem_q ? rd_a_q : {cqr_pkg::WORD_W{res_neg_q}};
			status_q    <= res_status_q;
			empty_out_q <= empty;
			full_out_q  <= full;
		end
	end

	assign data_out = data_out_q;
	assign status   = status_q;
	assign is_empty = empty_out_q;
	assign is_full  = full_out_q;

endmodule

[rtl/circular_queue_with_reverse_top.sv]
// Top level of the circular queue with in-place reverse.
// A ring-buffer queue of signed 32-bit words with SLOTS entries (one kept free, so at most
// SLOTS-1 words). Each input transfer carries an operation (enqueue, dequeue, peek, reverse)
// and yields exactly one result transfer with data, status and empty/full flags. Items are
// handled one at a time: each item is captured, executed and its result loaded into the
// output register before the next input transfer is taken; reverse of n stored words adds
// floor(n/2) swap steps, since each swapped pair needs one dual read and two writes
// through the store's single write port. The result sits in an output register, so a new
// item is taken while it waits to be read; that item then holds in its final state until
// the waiting result has been transferred.
module circular_queue_with_reverse_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic signed [31:0] data_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] data_out,
	output logic [1:0]         status,
	output logic               is_empty,
	output logic               is_full
);

	cqr_pkg::cmd_t     cmd;
	cqr_pkg::dp_stat_t dp_stat;

	cqr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_stat   (dp_stat),
		.cmd       (cmd)
	);

	cqr_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.dp_stat  (dp_stat),
		.op       (op),
		.data_in  (data_in),
		.data_out (data_out),
		.status   (status),
		.is_empty (is_empty),
		.is_full  (is_full)
	);

endmodule

[rtl/cqr_checker.sv]
// Port-level checker for the circular queue with reverse, bound to the top level.
module cqr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] data_out,
	input logic [1:0]  status,
	input logic        is_empty,
	input logic        is_full
);

	// A stalled result holds its data
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_out))
		else $error("result changed while stalled");

	// Queue cannot be empty and full at once
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_empty && is_full))
		else $error("empty and full both set");

	// A refused enqueue reports a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == cqr_pkg::ST_FULL |-> is_full)
		else $error("full refusal without full flag");

	// An empty refusal reports an empty queue
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == cqr_pkg::ST_EMPTY |-> is_empty)
		else $error("empty refusal without empty flag");

	// No new item is taken in the cycle right after a transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on consecutive cycles");

endmodule

bind circular_queue_with_reverse_top cqr_checker u_cqr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.data_out  (data_out),
	.status    (status),
	.is_empty  (is_empty),
	.is_full   (is_full)
);
